// ===== hw/rtl/weighted_table_sampler_assert.svh =====
// assertion macros for the weighted table sampler
// expects clk_i and rst_ni in the scope of the including module
`ifndef WEIGHTED_TABLE_SAMPLER_ASSERT_SVH
`define WEIGHTED_TABLE_SAMPLER_ASSERT_SVH

// same-cycle implication
`define WTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/wts_pkg.sv =====
// shared types and constants of the weighted table sampler
// used by wts_cell, wts_chain and weighted_table_sampler; no dependencies
`default_nettype none

package wts_pkg;

  // table geometry
  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W         = $clog2(TABLE_ENTRIES + 1);

  // arithmetic widths
  localparam int unsigned WEIGHT_IN_W = 32;
  localparam int unsigned WEIGHT_BITS = 32;
  localparam int unsigned CUM_W       = WEIGHT_BITS + IDX_W;
  localparam int unsigned FRAC_W      = 32;
  localparam int unsigned PROD_W      = FRAC_W + CUM_W;
  localparam int unsigned MUL_SPLIT   = 32;
  localparam int unsigned MUL_HI_W    = CUM_W - MUL_SPLIT;
  localparam int unsigned PLO_W       = FRAC_W + MUL_SPLIT;

  // operation codes
  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_DRAW  = 2'd2,
    FUNC_NOP   = 2'd3
  } wts_func_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_ZERO  = 2'd3
  } wts_status_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_LAUNCH,
    S_SCAN
  } wts_state_e;

  // input beat
  typedef struct packed {
    logic [1:0]             func;
    logic [WEIGHT_IN_W-1:0] weight;
    logic [6:0]             atomic_number;
    logic [8:0]             mass_number;
    logic [15:0]            excitation_kev;
    logic                   bias_flag;
    logic [FRAC_W-1:0]      random_fraction;
  } wts_in_t;

  // result beat
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  chosen_index;
    logic [6:0]  chosen_atomic_number;
    logic [8:0]  chosen_mass_number;
    logic [15:0] chosen_excitation_kev;
    logic        chosen_bias_flag;
  } wts_out_t;

  // stored entry fields
  typedef struct packed {
    logic [6:0]  atomic_number;
    logic [8:0]  mass_number;
    logic [15:0] excitation_kev;
    logic        bias_flag;
  } wts_entry_t;

  // table write broadcast
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [CUM_W-1:0] cum;
    wts_entry_t       ent;
  } wts_wr_t;

  // search token passed along the chain
  typedef struct packed {
    logic             valid;
    logic             found;
    logic [IDX_W-1:0] idx;
    wts_entry_t       ent;
  } wts_tok_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wts_cell.sv =====
// one table slot: stores an entry and its cumulative weight, forwards the search token
// depends on wts_pkg
`default_nettype none

module wts_cell (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [wts_pkg::IDX_W-1:0]   idx_i,
  input  wire logic [wts_pkg::CNT_W-1:0]   count_i,
  input  wire wts_pkg::wts_wr_t            wr_i,
  input  wire logic [wts_pkg::PROD_W-1:0]  prod_i,
  input  wire wts_pkg::wts_tok_t           tok_i,
  output wts_pkg::wts_tok_t                tok_o
);

  logic [wts_pkg::CUM_W-1:0] cum_q;
  wts_pkg::wts_entry_t       ent_q;
  wts_pkg::wts_tok_t         tok_d, tok_q;
  logic                      live;
  logic                      hit;

  // slot storage, written when the load address matches this slot
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.addr == idx_i)) begin
      cum_q <= wr_i.cum;
      ent_q <= wr_i.ent;
    end
  end

  // slot holds a loaded entry and passes the inverse-cdf compare
  assign live = ({1'b0, idx_i} < count_i);
  assign hit  = (prod_i <= {cum_q, {wts_pkg::FRAC_W{1'b0}}});

  // token update: first live slot that hits claims it, else keep latest live slot
  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.found && live) begin
      tok_d.idx   = idx_i;
      tok_d.ent   = ent_q;
      tok_d.found = hit;
    end
  end

  // token register to the next slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

`default_nettype wire

// ===== hw/rtl/wts_chain.sv =====
// row of table slots with the search token moving one slot per cycle
// depends on wts_pkg and wts_cell
`default_nettype none

module wts_chain (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [wts_pkg::CNT_W-1:0]   count_i,
  input  wire wts_pkg::wts_wr_t            wr_i,
  input  wire logic [wts_pkg::PROD_W-1:0]  prod_i,
  input  wire wts_pkg::wts_tok_t           tok_i,
  output wts_pkg::wts_tok_t                tok_o
);

  wts_pkg::wts_tok_t link [wts_pkg::TABLE_ENTRIES+1];

  assign link[0] = tok_i;

  // one cell per table slot
  for (genvar g = 0; g < wts_pkg::TABLE_ENTRIES; g++) begin : g_cell
    wts_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (wts_pkg::IDX_W'(g)),
      .count_i (count_i),
      .wr_i    (wr_i),
      .prod_i  (prod_i),
      .tok_i   (link[g]),
      .tok_o   (link[g+1])
    );
  end

  assign tok_o = link[wts_pkg::TABLE_ENTRIES];

endmodule

`default_nettype wire

// ===== hw/rtl/weighted_table_sampler.sv =====
// top level of the weighted table sampler: controller, draw product and slot chain
// depends on wts_pkg, wts_chain and weighted_table_sampler_assert.svh
//
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+-------------------
// request   | in        | start high while busy low  | req_i (wts_in_t)
// result    | out       | done_o high for one cycle  | rsp_o (wts_out_t)
//
// clear, load and no-op beats: result in the cycle after acceptance, busy stays low.
// draw beat: states S_MUL_LO and S_MUL_HI form the 72-bit product in two partial
// multiplies, S_LAUNCH launches the token, and the token then walks the slot chain
// one slot per cycle. draw on an empty table answers in the cycle after acceptance.
// reset clears the entry count and running total; the table has no clearing pass.
// the receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module weighted_table_sampler (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire wts_pkg::wts_in_t  req_i,
  output logic                   done_o,
  output wts_pkg::wts_out_t      rsp_o
);

  `include "weighted_table_sampler_assert.svh"

  wts_pkg::wts_state_e              state_d, state_q;
  logic [wts_pkg::CNT_W-1:0]        count_d, count_q;
  logic [wts_pkg::CUM_W-1:0]        total_d, total_q;
  logic [wts_pkg::FRAC_W-1:0]       frac_d, frac_q;
  logic [wts_pkg::PLO_W-1:0]        plo_d, plo_q;
  logic [wts_pkg::PROD_W-1:0]       prod_d, prod_q;
  wts_pkg::wts_out_t                rsp_d, rsp_q;
  logic                             done_d, done_q;
  wts_pkg::wts_wr_t                 wr;
  wts_pkg::wts_tok_t                tok_in, tok_out;
  logic [wts_pkg::WEIGHT_BITS-1:0]  w;
  logic [wts_pkg::CUM_W-1:0]        cum_new;
  logic [wts_pkg::PLO_W-1:0]        mul_lo;
  logic [wts_pkg::FRAC_W+wts_pkg::MUL_HI_W-1:0] mul_hi;
  logic                             draw_go;
  logic                             full_load;

  assign w       = req_i.weight[wts_pkg::WEIGHT_BITS-1:0];
  assign cum_new = total_q + wts_pkg::CUM_W'(w);
  assign mul_lo  = frac_q * total_q[wts_pkg::MUL_SPLIT-1:0];
  assign mul_hi  = frac_q * total_q[wts_pkg::CUM_W-1:wts_pkg::MUL_SPLIT];

  // next state and outputs
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    total_d      = total_q;
    frac_d       = frac_q;
    plo_d        = plo_q;
    prod_d       = prod_q;
    rsp_d        = rsp_q;
    done_d       = 1'b0;
    wr.en        = 1'b0;
    wr.addr      = count_q[wts_pkg::IDX_W-1:0];
    wr.cum       = cum_new;
    wr.ent.atomic_number  = req_i.atomic_number;
    wr.ent.mass_number    = req_i.mass_number;
    wr.ent.excitation_kev = req_i.excitation_kev;
    wr.ent.bias_flag      = req_i.bias_flag;
    tok_in       = '0;

    unique case (state_q)
      wts_pkg::S_IDLE: begin
        if (start) begin
          rsp_d = '0;
          unique case (wts_pkg::wts_func_e'(req_i.func))
            wts_pkg::FUNC_CLEAR: begin
              count_d = '0;
              total_d = '0;
              done_d  = 1'b1;
            end
            wts_pkg::FUNC_LOAD: begin
              done_d = 1'b1;
              priority if (w == '0) begin
                rsp_d.status = wts_pkg::ST_ZERO;
              end else if (count_q >= wts_pkg::CNT_W'(wts_pkg::TABLE_ENTRIES)) begin
                rsp_d.status = wts_pkg::ST_FULL;
              end else begin
                wr.en                       = 1'b1;
                total_d                     = cum_new;
                count_d                     = count_q + wts_pkg::CNT_W'(1);
                rsp_d.status                = wts_pkg::ST_OK;
                rsp_d.chosen_index          = 8'(count_q[wts_pkg::IDX_W-1:0]);
                rsp_d.chosen_atomic_number  = req_i.atomic_number;
                rsp_d.chosen_mass_number    = req_i.mass_number;
                rsp_d.chosen_excitation_kev = req_i.excitation_kev;
                rsp_d.chosen_bias_flag      = req_i.bias_flag;
              end
            end
            wts_pkg::FUNC_DRAW: begin
              if (count_q == '0) begin
                rsp_d.status = wts_pkg::ST_EMPTY;
                done_d       = 1'b1;
              end else begin
                frac_d  = req_i.random_fraction;
                state_d = wts_pkg::S_MUL_LO;
              end
            end
            wts_pkg::FUNC_NOP: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      // low partial product
      wts_pkg::S_MUL_LO: begin
        plo_d   = mul_lo;
        state_d = wts_pkg::S_MUL_HI;
      end
      // high partial product added in
      wts_pkg::S_MUL_HI: begin
        prod_d  = wts_pkg::PROD_W'(plo_q) + {mul_hi, {wts_pkg::MUL_SPLIT{1'b0}}};
        state_d = wts_pkg::S_LAUNCH;
      end
      // inject the search token at slot zero
      wts_pkg::S_LAUNCH: begin
        tok_in.valid = 1'b1;
        state_d      = wts_pkg::S_SCAN;
      end
      // wait for the token at the end of the chain
      wts_pkg::S_SCAN: begin
        if (tok_out.valid) begin
          rsp_d.status                = wts_pkg::ST_OK;
          rsp_d.chosen_index          = 8'(tok_out.idx);
          rsp_d.chosen_atomic_number  = tok_out.ent.atomic_number;
          rsp_d.chosen_mass_number    = tok_out.ent.mass_number;
          rsp_d.chosen_excitation_kev = tok_out.ent.excitation_kev;
          rsp_d.chosen_bias_flag      = tok_out.ent.bias_flag;
          done_d                      = 1'b1;
          state_d                     = wts_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = wts_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wts_pkg::S_IDLE;
      count_q <= '0;
      total_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      total_q <= total_d;
      done_q  <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    frac_q <= frac_d;
    plo_q  <= plo_d;
    prod_q <= prod_d;
    rsp_q  <= rsp_d;
  end

  // slot chain
  wts_chain u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .count_i (count_q),
    .wr_i    (wr),
    .prod_i  (prod_q),
    .tok_i   (tok_in),
    .tok_o   (tok_out)
  );

  assign busy   = (state_q != wts_pkg::S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // accepted draw on a loaded table, accepted load into a full table
  assign draw_go   = start && !busy && (req_i.func == 2'(wts_pkg::FUNC_DRAW)) &&
                     (count_q != '0);
  assign full_load = start && !busy && (req_i.func == 2'(wts_pkg::FUNC_LOAD)) &&
                     (count_q == wts_pkg::CNT_W'(wts_pkg::TABLE_ENTRIES));

  // checks
  `WTS_ASSERT_NEXT(a_draw_goes_busy, draw_go, busy, "draw did not start a scan")
  `WTS_ASSERT_NOW(a_token_only_in_scan, tok_out.valid, state_q == wts_pkg::S_SCAN, "stray token")
  `WTS_ASSERT_NOW(a_done_when_idle, done_q, !busy, "result beat while still busy")
  `WTS_ASSERT_NEXT(a_full_holds_count, full_load, $stable(count_q), "full load changed count")
  `WTS_ASSERT_NOW(a_token_found, tok_out.valid, tok_out.found, "no slot met the draw compare")

endmodule

`default_nettype wire
